/* src/two_channel_lux_conversion_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the lux conversion block
// Shared property wrappers, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_CHANNEL_LUX_CONVERSION_MACROS_SVH
`define TWO_CHANNEL_LUX_CONVERSION_MACROS_SVH

// same-cycle implication
`define TLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tlc_pkg.sv */
// ----------------------------------------------------------------------------
// tlc_pkg
// Types, constants and the ratio power table of the lux conversion block.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int POW_TABLE_DEPTH = 64;
    localparam int POW_IDX_W       = $clog2(POW_TABLE_DEPTH + 1);

    localparam int CNT_W   = 16;
    localparam int LUX_W   = 32;
    localparam int BRT_W   = 16;
    localparam int RATIO_W = 17;
    localparam int PROD_W  = 44;
    localparam int COEF_W  = 28;
    localparam int MS_W    = 16;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_HIGH_GAIN = 2'd0;
    localparam logic [IDX_W-1:0] REG_INTEG_MS  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MIN_LUX   = 2'd2;
    localparam logic [IDX_W-1:0] REG_MAX_LUX   = 2'd3;

    localparam logic [CNT_W-1:0] SAT_CODE    = 16'hFFFF;
    localparam logic [MS_W-1:0]  RST_INTEG   = 16'd402;
    localparam logic [LUX_W-1:0] RST_MAX_LUX = 32'd256000;
    localparam logic [8:0]       NORM_MS     = 9'd402;

    // ratio segment bounds, Q16
    localparam logic [RATIO_W-1:0] B_050 = 17'd32768;
    localparam logic [RATIO_W-1:0] B_061 = 17'd39977;
    localparam logic [RATIO_W-1:0] B_080 = 17'd52429;
    localparam logic [RATIO_W-1:0] B_130 = 17'd85197;

    // coefficients, Q32
    localparam logic [COEF_W-1:0] C0304  = 28'd130567006;
    localparam logic [COEF_W-1:0] C062   = 28'd266287972;
    localparam logic [COEF_W-1:0] C0224  = 28'd96207267;
    localparam logic [COEF_W-1:0] C031   = 28'd133143986;
    localparam logic [COEF_W-1:0] C0128  = 28'd54975581;
    localparam logic [COEF_W-1:0] C0153  = 28'd65713000;
    localparam logic [COEF_W-1:0] C00146 = 28'd6270652;
    localparam logic [COEF_W-1:0] C00112 = 28'd4810363;

    localparam int SEG_W = 3;
    localparam logic [SEG_W-1:0] SEG_LOW  = 3'd0;
    localparam logic [SEG_W-1:0] SEG_MID  = 3'd1;
    localparam logic [SEG_W-1:0] SEG_HIGH = 3'd2;
    localparam logic [SEG_W-1:0] SEG_TOP  = 3'd3;
    localparam logic [SEG_W-1:0] SEG_NONE = 3'd4;

    // divider cell widths and chain lengths
    localparam int DIV_DEN_W   = 32;
    localparam int DIV_NUM_W   = 48;
    localparam int DIV_QUO_W   = 32;
    localparam int RATIO_CELLS = 17;
    localparam int LUX_CELLS   = 32;
    localparam int BRT_CELLS   = 16;
    localparam int EVAL_LAT    = 5;

    localparam logic [63:0] ROOT_MAX = 64'd6400;

    typedef struct packed {
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_QUO_W-1:0] quo;
        logic [DIV_DEN_W-1:0] den;
    } t_div;

    typedef struct packed {
        logic             vld;
        logic             sat;
        logic             kill;
        logic             empty;
        logic [CNT_W-1:0] ch0;
        logic [CNT_W-1:0] ch1;
        logic [LUX_W-1:0] lux;
    } t_tag;

    typedef struct packed {
        logic             valid_res;
        logic [LUX_W-1:0] lux;
        logic [BRT_W-1:0] brightness;
    } t_res;

    typedef logic [15:0] t_pow_tab [0:POW_TABLE_DEPTH];

    // shift-subtract quotient, used only while building the table
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // r^1.4 in Q16 for r = i/(2*depth), via an integer fifth root of r^2 in Q13
    function automatic logic [15:0] f_pow_entry(input logic [63:0] i);
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] q1;
        logic [63:0] r1;
        logic [63:0] target;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        d      = 64'(POW_TABLE_DEPTH);
        m      = 64'd4 * d * d;
        a      = (i * i) << 30;
        q1     = f_udiv(a, m);
        r1     = a - q1 * m;
        target = (q1 << 35) + f_udiv(r1 << 35, m);
        lo     = 64'd0;
        hi     = ROOT_MAX;
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            p   = mid * mid * mid * mid * mid;
            if (p <= target) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return 16'(f_udiv(i * lo * 64'd4, d));
    endfunction

    function automatic t_pow_tab f_build_pow_tab();
        t_pow_tab t;
        for (int i = 0; i <= POW_TABLE_DEPTH; i++) begin
            t[i] = f_pow_entry(64'(i));
        end
        return t;
    endfunction

    localparam t_pow_tab POW_TAB = f_build_pow_tab();

endpackage

/* src/tlc_div_cell.sv */
// ----------------------------------------------------------------------------
// tlc_div_cell
// One restoring-division step: shifts in a numerator bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module tlc_div_cell (
    input  logic         i_clk,
    input  logic         i_en,
    input  tlc_pkg::t_div i_d,
    output tlc_pkg::t_div o_d
);

    tlc_pkg::t_div r_d;
    tlc_pkg::t_div n_d;

    logic [tlc_pkg::DIV_DEN_W:0] w_trial;
    logic [tlc_pkg::DIV_DEN_W:0] w_diff;
    logic                        w_ge;

    always_comb begin
        w_trial = {i_d.rem, i_d.num[tlc_pkg::DIV_NUM_W-1]};
        w_diff  = w_trial - {1'b0, i_d.den};
        // no borrow means the divisor fits
        w_ge    = ~w_diff[tlc_pkg::DIV_DEN_W];
        n_d.rem = w_ge ? w_diff[tlc_pkg::DIV_DEN_W-1:0] : w_trial[tlc_pkg::DIV_DEN_W-1:0];
        n_d.num = {i_d.num[tlc_pkg::DIV_NUM_W-2:0], 1'b0};
        n_d.quo = {i_d.quo[tlc_pkg::DIV_QUO_W-2:0], w_ge};
        n_d.den = i_d.den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

/* src/tlc_lux_eval.sv */
// ----------------------------------------------------------------------------
// tlc_lux_eval
// Segment select, ratio power interpolation and per-count lux value.
// ----------------------------------------------------------------------------
module tlc_lux_eval (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [tlc_pkg::RATIO_W-1:0]  i_ratio,
    input  logic [tlc_pkg::CNT_W-1:0]    i_ch0,
    input  logic [tlc_pkg::CNT_W-1:0]    i_ch1,
    output logic [tlc_pkg::PROD_W-1:0]   o_v,
    output logic                         o_kill
);

    localparam int XM_W = $clog2(2 * tlc_pkg::POW_TABLE_DEPTH + 1);
    localparam int X_W  = tlc_pkg::RATIO_W + XM_W;
    localparam int K_W  = X_W - 16;
    localparam logic [X_W-1:0] X_MULT = X_W'(2 * tlc_pkg::POW_TABLE_DEPTH);
    localparam logic [K_W-1:0] K_LAST = K_W'(tlc_pkg::POW_TABLE_DEPTH);

    // stage 1
    logic [X_W-1:0]               w_x;
    logic [K_W-1:0]               w_k;
    logic [tlc_pkg::POW_IDX_W-1:0] w_kidx;
    logic [15:0]                  w_a;
    logic [15:0]                  w_b;
    logic [15:0]                  w_delta;
    logic [tlc_pkg::SEG_W-1:0]    w_seg;

    logic [15:0]               r1_a;
    logic [15:0]               r1_delta;
    logic [15:0]               r1_f;
    logic [tlc_pkg::SEG_W-1:0] r1_seg;
    logic [tlc_pkg::CNT_W-1:0] r1_ch0;
    logic [tlc_pkg::CNT_W-1:0] r1_ch1;

    // stage 2
    logic [tlc_pkg::COEF_W-1:0] w_cpos;
    logic [tlc_pkg::COEF_W-1:0] w_cneg;
    logic [31:0]                w_interp;

    logic [15:0]                r2_p;
    logic [tlc_pkg::PROD_W-1:0] r2_pos;
    logic [tlc_pkg::PROD_W-1:0] r2_nlin;
    logic [tlc_pkg::SEG_W-1:0]  r2_seg;
    logic [tlc_pkg::CNT_W-1:0]  r2_ch0;

    // stage 3, 4
    logic [31:0]                r3_m1;
    logic [tlc_pkg::PROD_W-1:0] r3_pos;
    logic [tlc_pkg::PROD_W-1:0] r3_nlin;
    logic [tlc_pkg::SEG_W-1:0]  r3_seg;

    logic [59:0]                r4_m2;
    logic [tlc_pkg::PROD_W-1:0] r4_pos;
    logic [tlc_pkg::PROD_W-1:0] r4_nlin;
    logic [tlc_pkg::SEG_W-1:0]  r4_seg;

    // stage 5
    logic [tlc_pkg::PROD_W-1:0] w_neg;
    logic [tlc_pkg::PROD_W-1:0] r5_v;
    logic                       r5_kill;

    always_comb begin
        w_x    = X_W'(i_ratio) * X_MULT;
        w_k    = w_x[X_W-1:16];
        w_kidx = w_k[tlc_pkg::POW_IDX_W-1:0];
        if (w_k >= K_LAST) begin
            w_a = tlc_pkg::POW_TAB[tlc_pkg::POW_TABLE_DEPTH];
            w_b = w_a;
        end else begin
            w_a = tlc_pkg::POW_TAB[w_kidx];
            w_b = tlc_pkg::POW_TAB[w_kidx + 1'b1];
        end
        w_delta = (w_b < w_a) ? 16'd0 : (w_b - w_a);

        if (i_ratio < tlc_pkg::B_050) begin
            w_seg = tlc_pkg::SEG_LOW;
        end else if (i_ratio < tlc_pkg::B_061) begin
            w_seg = tlc_pkg::SEG_MID;
        end else if (i_ratio < tlc_pkg::B_080) begin
            w_seg = tlc_pkg::SEG_HIGH;
        end else if (i_ratio < tlc_pkg::B_130) begin
            w_seg = tlc_pkg::SEG_TOP;
        end else begin
            w_seg = tlc_pkg::SEG_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a     <= w_a;
            r1_delta <= w_delta;
            r1_f     <= w_x[15:0];
            r1_seg   <= w_seg;
            r1_ch0   <= i_ch0;
            r1_ch1   <= i_ch1;
        end
    end

    always_comb begin
        case (r1_seg)
            tlc_pkg::SEG_LOW: begin
                w_cpos = tlc_pkg::C0304;
                w_cneg = '0;
            end
            tlc_pkg::SEG_MID: begin
                w_cpos = tlc_pkg::C0224;
                w_cneg = tlc_pkg::C031;
            end
            tlc_pkg::SEG_HIGH: begin
                w_cpos = tlc_pkg::C0128;
                w_cneg = tlc_pkg::C0153;
            end
            tlc_pkg::SEG_TOP: begin
                w_cpos = tlc_pkg::C00146;
                w_cneg = tlc_pkg::C00112;
            end
            default: begin
                w_cpos = '0;
                w_cneg = '0;
            end
        endcase
        w_interp = 32'(r1_delta) * 32'(r1_f);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p    <= r1_a + w_interp[31:16];
            r2_pos  <= tlc_pkg::PROD_W'(w_cpos) * tlc_pkg::PROD_W'(r1_ch0);
            r2_nlin <= tlc_pkg::PROD_W'(w_cneg) * tlc_pkg::PROD_W'(r1_ch1);
            r2_seg  <= r1_seg;
            r2_ch0  <= r1_ch0;

            r3_m1   <= 32'(r2_ch0) * 32'(r2_p);
            r3_pos  <= r2_pos;
            r3_nlin <= r2_nlin;
            r3_seg  <= r2_seg;

            r4_m2   <= 60'(r3_m1) * 60'(tlc_pkg::C062);
            r4_pos  <= r3_pos;
            r4_nlin <= r3_nlin;
            r4_seg  <= r3_seg;
        end
    end

    assign w_neg = (r4_seg == tlc_pkg::SEG_LOW) ? r4_m2[59:16] : r4_nlin;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_v    <= (r4_pos > w_neg) ? (r4_pos - w_neg) : '0;
            r5_kill <= (r4_seg == tlc_pkg::SEG_NONE);
        end
    end

    assign o_v    = r5_v;
    assign o_kill = r5_kill;

endmodule

/* src/tlc_out_buf.sv */
// ----------------------------------------------------------------------------
// tlc_out_buf
// Output register with one skid entry; a full skid holds the pipeline.
// ----------------------------------------------------------------------------
module tlc_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  tlc_pkg::t_res i_res,
    input  logic          i_stall,
    output logic          o_full,
    output logic          o_valid,
    output tlc_pkg::t_res o_res
);

    logic          r_valid;
    logic          r_full;
    logic          n_valid;
    logic          n_full;
    tlc_pkg::t_res r_res;
    tlc_pkg::t_res r_skid;
    logic          w_take;
    logic          w_ld_out;
    logic          w_ld_skid;
    logic          w_from_skid;

    assign w_take = r_valid & ~i_stall;

    always_comb begin
        n_valid     = r_valid;
        n_full      = r_full;
        w_ld_out    = 1'b0;
        w_ld_skid   = 1'b0;
        w_from_skid = 1'b0;
        if (!r_full) begin
            if (i_vld) begin
                if (!r_valid || w_take) begin
                    w_ld_out = 1'b1;
                    n_valid  = 1'b1;
                end else begin
                    w_ld_skid = 1'b1;
                    n_full    = 1'b1;
                end
            end else if (w_take) begin
                n_valid = 1'b0;
            end
        end else if (w_take) begin
            w_ld_out    = 1'b1;
            w_from_skid = 1'b1;
            n_full      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_full  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_full  <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_res <= w_from_skid ? r_skid : i_res;
        end
        if (w_ld_skid) begin
            r_skid <= i_res;
        end
    end

    assign o_full  = r_full;
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* src/two_channel_lux_conversion.sv */
// ----------------------------------------------------------------------------
// two_channel_lux_conversion
// Broadband/infrared sample pair to lux (Q24.8) and clamped brightness (Q0.16).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid with the two counts; a transaction completes on
//   an edge with i_in_valid high and o_in_stall low. Output channel:
//   o_out_valid with valid_res, lux and brightness; taken when i_out_stall
//   is low. One result per sample pair, in order.
//   Throughput is one pair per cycle while o_in_stall is low. From the accepting
//   edge to o_out_valid a pair passes the input register, the three restoring-divider
//   cell rows (17 ratio bits, 32 lux bits, 16 brightness bits, one bit per
//   cell), the five-stage segment evaluator and the prep and output registers.
//   The output has a register and one skid entry. When the receiver stalls,
//   results collect there; once the skid entry fills, o_in_stall rises and
//   the whole pipeline holds until the output is taken.
//   Configuration writes land on i_cfg_we and must happen only when idle.
//   Synchronous reset empties the pipeline and loads high_gain 0,
//   integration 402 ms, min_lux 0 and max_lux 256000 (Q24.8).
// ----------------------------------------------------------------------------
`include "two_channel_lux_conversion_macros.svh"

module two_channel_lux_conversion (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [tlc_pkg::CNT_W-1:0]   i_broadband_count,
    input  logic [tlc_pkg::CNT_W-1:0]   i_infrared_count,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_valid_res,
    output logic [tlc_pkg::LUX_W-1:0]   o_lux,
    output logic [tlc_pkg::BRT_W-1:0]   o_brightness,
    input  logic                        i_cfg_we,
    input  logic [tlc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [tlc_pkg::CFG_W-1:0]   i_cfg_data
);

    // configuration
    logic                       r_high_gain;
    logic [tlc_pkg::MS_W-1:0]   r_integ_ms;
    logic [tlc_pkg::LUX_W-1:0]  r_min_lux;
    logic [tlc_pkg::LUX_W-1:0]  r_max_lux;

    logic w_adv;
    logic w_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_gain <= 1'b0;
            r_integ_ms  <= tlc_pkg::RST_INTEG;
            r_min_lux   <= '0;
            r_max_lux   <= tlc_pkg::RST_MAX_LUX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlc_pkg::REG_HIGH_GAIN: r_high_gain <= i_cfg_data[0];
                tlc_pkg::REG_INTEG_MS:  r_integ_ms  <= i_cfg_data[tlc_pkg::MS_W-1:0];
                tlc_pkg::REG_MIN_LUX:   r_min_lux   <= i_cfg_data;
                tlc_pkg::REG_MAX_LUX:   r_max_lux   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_adv      = ~w_out_full;
    assign o_in_stall = w_out_full;

    // input stage
    tlc_pkg::t_tag r_a;
    tlc_pkg::t_tag n_a;

    always_comb begin
        n_a       = '0;
        n_a.vld   = i_in_valid;
        n_a.ch0   = i_broadband_count;
        n_a.ch1   = i_infrared_count;
        n_a.sat   = (i_broadband_count == tlc_pkg::SAT_CODE) |
                    (i_infrared_count == tlc_pkg::SAT_CODE);
        // ratio of 2 or more, zero broadband or zero integration time give lux 0
        n_a.kill  = ({1'b0, i_infrared_count} >= {i_broadband_count, 1'b0}) |
                    (i_broadband_count == '0) | (r_integ_ms == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
        end else if (w_adv) begin
            r_a <= n_a;
        end
    end

    // ratio cell row: quotient of ch1*2^16 / ch0, top bits known zero
    tlc_pkg::t_div w_rd [tlc_pkg::RATIO_CELLS+1];
    tlc_pkg::t_tag r_tr [tlc_pkg::RATIO_CELLS];

    always_comb begin
        w_rd[0]     = '0;
        w_rd[0].rem = tlc_pkg::DIV_DEN_W'(r_a.ch1[tlc_pkg::CNT_W-1:1]);
        w_rd[0].num = {r_a.ch1[0], {(tlc_pkg::DIV_NUM_W-1){1'b0}}};
        w_rd[0].den = tlc_pkg::DIV_DEN_W'(r_a.ch0);
    end

    for (genvar g = 0; g < tlc_pkg::RATIO_CELLS; g++) begin : g_ratio
        tlc_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_d   (w_rd[g]),
            .o_d   (w_rd[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tlc_pkg::RATIO_CELLS; i++) r_tr[i] <= '0;
        end else if (w_adv) begin
            r_tr[0] <= r_a;
            for (int i = 1; i < tlc_pkg::RATIO_CELLS; i++) r_tr[i] <= r_tr[i-1];
        end
    end

    // segment evaluation
    logic [tlc_pkg::PROD_W-1:0] w_v;
    logic                       w_eval_kill;
    tlc_pkg::t_tag              r_te [tlc_pkg::EVAL_LAT];

    tlc_lux_eval u_eval (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_ratio (w_rd[tlc_pkg::RATIO_CELLS].quo[tlc_pkg::RATIO_W-1:0]),
        .i_ch0   (r_tr[tlc_pkg::RATIO_CELLS-1].ch0),
        .i_ch1   (r_tr[tlc_pkg::RATIO_CELLS-1].ch1),
        .o_v     (w_v),
        .o_kill  (w_eval_kill)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tlc_pkg::EVAL_LAT; i++) r_te[i] <= '0;
        end else if (w_adv) begin
            r_te[0] <= r_tr[tlc_pkg::RATIO_CELLS-1];
            for (int i = 1; i < tlc_pkg::EVAL_LAT; i++) r_te[i] <= r_te[i-1];
        end
    end

    // scale to 402 ms and 16x gain, drop the 2^24 part of the divisor
    logic [52:0]               w_scaled;
    logic [56:0]               w_gained;
    tlc_pkg::t_tag             r_s;
    tlc_pkg::t_tag             n_s;
    logic [tlc_pkg::LUX_W-1:0] r_s_num;

    always_comb begin
        w_scaled = 53'(w_v) * 53'(tlc_pkg::NORM_MS);
        w_gained = r_high_gain ? 57'(w_scaled) : {w_scaled, 4'b0};
        n_s      = r_te[tlc_pkg::EVAL_LAT-1];
        n_s.kill = r_te[tlc_pkg::EVAL_LAT-1].kill | w_eval_kill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else if (w_adv) begin
            r_s <= n_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s_num <= w_gained[55:24];
        end
    end

    // lux cell row: divide by integration time
    tlc_pkg::t_div w_ld [tlc_pkg::LUX_CELLS+1];
    tlc_pkg::t_tag r_tl [tlc_pkg::LUX_CELLS];

    always_comb begin
        w_ld[0]     = '0;
        w_ld[0].num = {r_s_num, {(tlc_pkg::DIV_NUM_W-tlc_pkg::LUX_W){1'b0}}};
        w_ld[0].den = tlc_pkg::DIV_DEN_W'(r_integ_ms);
    end

    for (genvar g = 0; g < tlc_pkg::LUX_CELLS; g++) begin : g_lux
        tlc_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_d   (w_ld[g]),
            .o_d   (w_ld[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tlc_pkg::LUX_CELLS; i++) r_tl[i] <= '0;
        end else if (w_adv) begin
            r_tl[0] <= r_s;
            for (int i = 1; i < tlc_pkg::LUX_CELLS; i++) r_tl[i] <= r_tl[i-1];
        end
    end

    // brightness prep: final lux, clamp, numerator and range
    tlc_pkg::t_tag             r_p1;
    tlc_pkg::t_tag             n_p1;
    tlc_pkg::t_tag             r_p2;
    tlc_pkg::t_tag             n_p2;
    tlc_pkg::t_tag             r_p3;
    logic [tlc_pkg::LUX_W-1:0] r_p2_lm;
    logic [tlc_pkg::LUX_W-1:0] w_lm;
    logic [tlc_pkg::LUX_W-1:0] w_diff;
    logic [tlc_pkg::DIV_NUM_W-1:0] w_num48;
    tlc_pkg::t_div             n_p3_div;
    tlc_pkg::t_div             r_p3_div;

    always_comb begin
        n_p1     = r_tl[tlc_pkg::LUX_CELLS-1];
        n_p1.lux = (n_p1.sat | n_p1.kill) ? '0 : w_ld[tlc_pkg::LUX_CELLS].quo;

        if (r_p1.lux < r_min_lux) begin
            w_lm = r_min_lux;
        end else if (r_p1.lux > r_max_lux) begin
            w_lm = r_max_lux;
        end else begin
            w_lm = r_p1.lux;
        end
        n_p2       = r_p1;
        n_p2.empty = (r_max_lux <= r_min_lux);

        // (lm - min) * 65535, quotient below 2^16 so the top half seeds the remainder
        w_diff       = r_p2_lm - r_min_lux;
        w_num48      = {w_diff, 16'b0} - tlc_pkg::DIV_NUM_W'(w_diff);
        n_p3_div     = '0;
        n_p3_div.rem = w_num48[tlc_pkg::DIV_NUM_W-1:16];
        n_p3_div.num = {w_num48[15:0], {(tlc_pkg::DIV_NUM_W-16){1'b0}}};
        n_p3_div.den = r_max_lux - r_min_lux;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= '0;
            r_p2 <= '0;
            r_p3 <= '0;
        end else if (w_adv) begin
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= r_p2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p2_lm  <= w_lm;
            r_p3_div <= n_p3_div;
        end
    end

    // brightness cell row
    tlc_pkg::t_div w_bd [tlc_pkg::BRT_CELLS+1];
    tlc_pkg::t_tag r_tb [tlc_pkg::BRT_CELLS];

    assign w_bd[0] = r_p3_div;

    for (genvar g = 0; g < tlc_pkg::BRT_CELLS; g++) begin : g_brt
        tlc_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_d   (w_bd[g]),
            .o_d   (w_bd[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tlc_pkg::BRT_CELLS; i++) r_tb[i] <= '0;
        end else if (w_adv) begin
            r_tb[0] <= r_p3;
            for (int i = 1; i < tlc_pkg::BRT_CELLS; i++) r_tb[i] <= r_tb[i-1];
        end
    end

    // output
    tlc_pkg::t_res w_res;
    tlc_pkg::t_res w_out_res;

    always_comb begin
        w_res.valid_res  = ~r_tb[tlc_pkg::BRT_CELLS-1].sat;
        w_res.lux        = r_tb[tlc_pkg::BRT_CELLS-1].lux;
        w_res.brightness = r_tb[tlc_pkg::BRT_CELLS-1].empty ? '0 :
                           w_bd[tlc_pkg::BRT_CELLS].quo[tlc_pkg::BRT_W-1:0];
    end

    tlc_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_tb[tlc_pkg::BRT_CELLS-1].vld),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_full  (w_out_full),
        .o_valid (o_out_valid),
        .o_res   (w_out_res)
    );

    assign o_valid_res  = w_out_res.valid_res;
    assign o_lux        = w_out_res.lux;
    assign o_brightness = w_out_res.brightness;

    // assertions
    `TLC_ASSERT_NOW(a_skid_needs_out, w_out_full, o_out_valid, "skid full with empty output")
    `TLC_ASSERT_NOW(a_sat_zero_lux, o_out_valid && !o_valid_res, o_lux == '0, "saturated lux")
    `TLC_ASSERT_NOW(a_empty_range, o_out_valid && (r_max_lux <= r_min_lux), o_brightness == '0, "range")
    `TLC_ASSERT_NEXT(a_skid_drain, w_out_full && i_out_stall, w_out_full, "skid lost under stall")

endmodule

/* sim/lux_checker.sv */
// ----------------------------------------------------------------------------
// lux_checker
// Watches both channels of the lux conversion block, predicts lux and
// brightness for every accepted sample pair and compares them in order.
// ----------------------------------------------------------------------------
module lux_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [tlc_pkg::CNT_W-1:0]   i_broadband_count,
    input  logic [tlc_pkg::CNT_W-1:0]   i_infrared_count,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_valid_res,
    input  logic [tlc_pkg::LUX_W-1:0]   i_lux,
    input  logic [tlc_pkg::BRT_W-1:0]   i_brightness,
    input  logic                        i_cfg_we,
    input  logic [tlc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [tlc_pkg::CFG_W-1:0]   i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import tlc_pkg::*;

    localparam int DEPTH = POW_TABLE_DEPTH;

    logic [63:0]      root_tab [0:DEPTH];
    logic             gain16;
    logic [MS_W-1:0]  integ_ms;
    logic [LUX_W-1:0] lux_lo;
    logic [LUX_W-1:0] lux_hi;
    t_res             expected_q[$];
    int               fail_count = 0;

    // r^1.4 in Q16 for r = i/(2*DEPTH): fifth root of r^2 in Q13, times r
    function automatic logic [63:0] ratio_pow(input logic [63:0] i);
        logic [63:0] m, a, tgt, lo, hi, mid;
        m   = 64'd4 * DEPTH * DEPTH;
        a   = (i * i) << 30;
        tgt = ((a / m) << 35) + (((a % m) << 35) / m);
        lo  = 0;
        hi  = 64'd6400;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid * mid * mid * mid <= tgt) lo = mid;
            else hi = mid - 1;
        end
        return 64'(16'((i * lo * 4) / DEPTH));
    endfunction

    function automatic logic [63:0] sub_floor(input logic [63:0] p, input logic [63:0] n);
        return (p > n) ? p - n : 64'd0;
    endfunction

    function automatic logic [LUX_W-1:0] lux_of(input logic [63:0] c0, input logic [63:0] c1);
        logic [63:0] ratio, x, k, f, pw, v, lx;
        if (c0 == 0 || integ_ms == 0) return '0;
        ratio = (c1 << 16) / c0;
        if (ratio < B_050) begin
            x = ratio * 2 * DEPTH;
            k = x >> 16;
            f = x & 64'hFFFF;
            if (k >= DEPTH) pw = root_tab[DEPTH];
            else if (root_tab[k+1] < root_tab[k]) pw = root_tab[k];
            else pw = root_tab[k] + (((root_tab[k+1] - root_tab[k]) * f) >> 16);
            v = sub_floor(64'(C0304) * c0, ((64'(C062) * c0) * pw) >> 16);
        end else if (ratio < B_061) begin
            v = sub_floor(64'(C0224) * c0, 64'(C031) * c1);
        end else if (ratio < B_080) begin
            v = sub_floor(64'(C0128) * c0, 64'(C0153) * c1);
        end else if (ratio < B_130) begin
            v = sub_floor(64'(C00146) * c0, 64'(C00112) * c1);
        end else begin
            return '0;
        end
        lx = (v * (64'd402 * (gain16 ? 64'd1 : 64'd16))) / (64'(integ_ms) << 24);
        return (lx > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lx[31:0];
    endfunction

    function automatic logic [BRT_W-1:0] brightness_of(input logic [LUX_W-1:0] lx);
        logic [63:0] l;
        if (lux_hi <= lux_lo) return '0;
        l = lx;
        if (l < lux_lo) l = lux_lo;
        if (l > lux_hi) l = lux_hi;
        return 16'(((l - lux_lo) * 64'd65535) / (64'(lux_hi) - lux_lo));
    endfunction

    initial begin
        for (int i = 0; i <= DEPTH; i++) root_tab[i] = ratio_pow(64'(i));
    end

    assign o_fail_count = fail_count;
    assign o_pending    = expected_q.size();

    always @(posedge i_clk) begin
        t_res exp_r;
        t_res got;
        if (!i_rst_n) begin
            gain16   <= 1'b0;
            integ_ms <= RST_INTEG;
            lux_lo   <= '0;
            lux_hi   <= RST_MAX_LUX;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HIGH_GAIN: gain16   <= i_cfg_data[0];
                    REG_INTEG_MS:  integ_ms <= i_cfg_data[MS_W-1:0];
                    REG_MIN_LUX:   lux_lo   <= i_cfg_data;
                    REG_MAX_LUX:   lux_hi   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                exp_r.valid_res = !(i_broadband_count == SAT_CODE
                                    || i_infrared_count == SAT_CODE);
                exp_r.lux = exp_r.valid_res ?
                    lux_of(64'(i_broadband_count), 64'(i_infrared_count)) : '0;
                exp_r.brightness = brightness_of(exp_r.lux);
                expected_q.push_back(exp_r);
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_valid_res, i_lux, i_brightness};
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction: %p", got);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected valid=%0d lux=%h bright=%h,",
                                      " got valid=%0d lux=%h bright=%h"},
                                     exp_r.valid_res, exp_r.lux, exp_r.brightness,
                                     got.valid_res, got.lux, got.brightness);
                    end
                end
            end
        end
    end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the lux conversion block: directed corner pairs, then random
// pairs under several register settings, with random idles on both channels.
// ----------------------------------------------------------------------------
module tb;
    import tlc_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [CNT_W-1:0] i_broadband_count;
    logic [CNT_W-1:0] i_infrared_count;
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_valid_res;
    logic [LUX_W-1:0] o_lux;
    logic [BRT_W-1:0] o_brightness;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    int               fail_count;
    int               pending;
    logic             steady;

    two_channel_lux_conversion u_top (.*);

    lux_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid,
        .i_in_stall   (o_in_stall),
        .i_broadband_count, .i_infrared_count,
        .i_out_valid  (o_out_valid),
        .i_out_stall,
        .i_valid_res  (o_valid_res),
        .i_lux        (o_lux),
        .i_brightness (o_brightness),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial i_out_stall = 1'b0;
    always @(posedge i_clk) begin
        i_out_stall <= steady ? 1'b0 : ($urandom_range(99) < 26);
    end

    task automatic send_pair(input logic [CNT_W-1:0] c0, input logic [CNT_W-1:0] c1);
        logic taken;
        // idle cycles drawn one at a time, about a quarter of all cycles
        while (!steady && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_broadband_count <= c0;
        i_infrared_count  <= c1;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic gain, input logic [15:0] ms,
                              input logic [31:0] lo, input logic [31:0] hi);
        i_cfg_we <= 1'b1; i_cfg_idx <= REG_HIGH_GAIN; i_cfg_data <= 32'(gain);
        @(posedge i_clk);
        i_cfg_idx <= REG_INTEG_MS; i_cfg_data <= 32'(ms);
        @(posedge i_clk);
        i_cfg_idx <= REG_MIN_LUX; i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx <= REG_MAX_LUX; i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly pairs spread over the ratio segments, some raw noise
    task automatic random_pairs(input int n);
        logic [CNT_W-1:0] c0, c1;
        for (int k = 0; k < n; k++) begin
            steady = (k >= n / 2 && k < n / 2 + 25);
            case ($urandom_range(9))
                0: begin c0 = $urandom; c1 = $urandom; end
                1: begin c0 = $urandom_range(0, 3); c1 = $urandom_range(0, 3); end
                2: begin c0 = $urandom; c1 = SAT_CODE; end
                3: begin c0 = $urandom_range(0, 64); c1 = $urandom_range(0, 100); end
                default: begin
                    c0 = $urandom_range(1, 65534);
                    c1 = 16'((64'(c0) * $urandom_range(0, 1500)) / 1000);
                end
            endcase
            send_pair(c0, c1);
        end
        steady = 1'b0;
    endtask

    initial begin
        steady            = 1'b0;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_broadband_count = '0;
        i_infrared_count  = '0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = REG_HIGH_GAIN;
        i_cfg_data        = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners at reset settings
        send_pair(16'd0, 16'd0);
        send_pair(16'd0, 16'd100);
        send_pair(SAT_CODE, 16'd10);
        send_pair(16'd10, SAT_CODE);
        send_pair(SAT_CODE, SAT_CODE);
        send_pair(16'hFFFE, 16'd0);
        send_pair(16'hFFFE, 16'hFFFE);
        send_pair(16'd1000, 16'd499);
        send_pair(16'd1000, 16'd500);
        send_pair(16'd1000, 16'd610);
        send_pair(16'd1000, 16'd800);
        send_pair(16'd1000, 16'd1299);
        send_pair(16'd1000, 16'd1300);
        send_pair(16'd1, 16'hFFFE);
        send_pair(16'hAAAA, 16'h5555);
        send_pair(16'h5555, 16'h2AAA);
        send_pair(16'd40000, 16'd8000);
        drain();

        write_regs(1'b1, 16'd402, 32'd0, 32'hFFFF_FFFF);
        random_pairs(80);
        drain();
        write_regs(1'b0, 16'd1, 32'd1000, 32'd5000000);
        send_pair(16'hFFFE, 16'd0);
        random_pairs(80);
        drain();
        write_regs(1'b1, 16'hFFFF, 32'd0, 32'd4000);
        random_pairs(80);
        drain();
        write_regs(1'b0, 16'd0, 32'd100, 32'd100);
        random_pairs(30);
        drain();
        write_regs(1'b0, 16'd13, 32'hFFFF_FFFF, 32'd10);
        random_pairs(30);
        drain();
        write_regs(1'b0, 16'($urandom_range(1, 1000)), 32'($urandom_range(0, 2000)),
                   32'($urandom_range(50000, 3000000)));
        random_pairs(100);
        drain();

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/tlc_pkg.sv
src/tlc_div_cell.sv
src/tlc_lux_eval.sv
src/tlc_out_buf.sv
src/two_channel_lux_conversion.sv
sim/lux_checker.sv
sim/tb.sv
